// ===== src/mtep_pkg.sv =====
package mtep_pkg;

    localparam int unsigned MAX_DELTA_BYTES = 4;

    localparam logic [3:0]  HEADER_BYTES  = 4'd8;
    localparam logic [23:0] TEMPO_DEFAULT = 24'd500000;
    localparam logic [7:0]  META_MARK     = 8'hFF;
    localparam logic [7:0]  META_END      = 8'h2F;
    localparam logic [7:0]  META_TEMPO    = 8'h51;

    localparam logic [1:0] KIND_CHANNEL = 2'd0;
    localparam logic [1:0] KIND_TEMPO   = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    localparam logic [3:0] PH_HEADER     = 4'd0;
    localparam logic [3:0] PH_DELTA      = 4'd1;
    localparam logic [3:0] PH_EVENT      = 4'd2;
    localparam logic [3:0] PH_META_TYPE  = 4'd3;
    localparam logic [3:0] PH_END_LEN    = 4'd4;
    localparam logic [3:0] PH_TEMPO_LEN  = 4'd5;
    localparam logic [3:0] PH_TEMPO_DATA = 4'd6;
    localparam logic [3:0] PH_META_LEN   = 4'd7;
    localparam logic [3:0] PH_META_SKIP  = 4'd8;
    localparam logic [3:0] PH_DATA1      = 4'd9;
    localparam logic [3:0] PH_DATA2      = 4'd10;

    localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
    localparam logic [3:0] NIB_POLY_AT   = 4'hA;
    localparam logic [3:0] NIB_CONTROL   = 4'hB;
    localparam logic [3:0] NIB_PROGRAM   = 4'hC;
    localparam logic [3:0] NIB_CHAN_AT   = 4'hD;
    localparam logic [3:0] NIB_PITCH     = 4'hE;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [7:0]  status_byte;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic        has_second;
        logic [27:0] delta_ticks;
        logic [23:0] tempo_us;
    } result_t;

    function automatic logic is_short_status(input logic [3:0] nib);
        return (nib == NIB_PROGRAM) || (nib == NIB_CHAN_AT);
    endfunction

    function automatic logic is_long_status(input logic [3:0] nib);
        return (nib == NIB_NOTE_OFF) || (nib == NIB_NOTE_ON) || (nib == NIB_POLY_AT) ||
               (nib == NIB_CONTROL) || (nib == NIB_PITCH);
    endfunction

endpackage

// ===== src/midi_track_event_parser.sv =====
// The input register holds each byte; an event's result is then registered in out_reg.
// One byte per cycle while no result stalls; the input register feeds the parser state.
// A result waiting for m_ready holds the parser; one further byte is taken meanwhile.
// Synchronous active-low reset: header skip of 8 bytes, delta and holds cleared,
// tempo set to 500000 us per quarter note, no item held in either register.
module midi_track_event_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_track_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_kind,
    output logic [7:0]  m_status_byte,
    output logic [7:0]  m_first_data,
    output logic [7:0]  m_second_data,
    output logic        m_has_second,
    output logic [27:0] m_delta_ticks,
    output logic [23:0] m_tempo_us
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_start_reg;
    logic               out_valid_reg;
    mtep_pkg::result_t  out_reg;
    mtep_pkg::result_t  result;
    logic               emit;
    logic               step;

    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    mtep_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .data_byte   (in_byte_reg),
        .track_start (in_start_reg),
        .emit        (emit),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg  <= s_data_byte;
            in_start_reg <= s_track_start;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && emit) begin
            out_reg <= result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_event_kind  = out_reg.event_kind;
    assign m_status_byte = out_reg.status_byte;
    assign m_first_data  = out_reg.first_data;
    assign m_second_data = out_reg.second_data;
    assign m_has_second  = out_reg.has_second;
    assign m_delta_ticks = out_reg.delta_ticks;
    assign m_tempo_us    = out_reg.tempo_us;

    a_chan_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_kind == mtep_pkg::KIND_CHANNEL) |-> m_status_byte[7])
        else $error("channel item without status bit");

    a_other_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_kind != mtep_pkg::KIND_CHANNEL) |->
        (m_status_byte == 8'd0) && (m_first_data == 8'd0) && !m_has_second)
        else $error("non-channel item carries message bytes");

    a_short_msg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_second |-> (m_second_data == 8'd0))
        else $error("second data byte set on two-byte item");

    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !(step && emit) |=> !m_valid)
        else $error("result item repeated");

endmodule

// ===== src/mtep_parser.sv =====
module mtep_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic [7:0]           data_byte,
    input  logic                 track_start,
    output logic                 emit,
    output mtep_pkg::result_t    result
);

    logic [3:0]  phase_reg,  phase_next;
    logic [3:0]  hdr_reg,    hdr_next;
    logic [27:0] acc_reg,    acc_next;
    logic [2:0]  dbytes_reg, dbytes_next;
    logic [7:0]  hstat_reg,  hstat_next;
    logic [7:0]  hdata_reg,  hdata_next;
    logic [7:0]  mleft_reg,  mleft_next;
    logic [23:0] tempo_reg,  tempo_next;
    logic [1:0]  tbytes_reg, tbytes_next;
    logic        done_reg,   done_next;

    always_comb begin
        logic [3:0] hdr_dec;
        logic [7:0] mleft_dec;
        phase_next  = phase_reg;
        hdr_next    = hdr_reg;
        acc_next    = acc_reg;
        dbytes_next = dbytes_reg;
        hstat_next  = hstat_reg;
        hdata_next  = hdata_reg;
        mleft_next  = mleft_reg;
        tempo_next  = tempo_reg;
        tbytes_next = tbytes_reg;
        done_next   = done_reg;
        emit        = 1'b0;
        result      = '0;
        hdr_dec     = '0;
        mleft_dec   = '0;

        if (track_start) begin
            phase_next  = mtep_pkg::PH_HEADER;
            hdr_next    = mtep_pkg::HEADER_BYTES;
            acc_next    = '0;
            dbytes_next = '0;
            hstat_next  = '0;
            hdata_next  = '0;
            mleft_next  = '0;
            tbytes_next = '0;
            done_next   = 1'b0;
        end

        result.delta_ticks = acc_next;
        result.tempo_us    = tempo_next;

        if (!done_next) begin
            unique case (phase_next)
                mtep_pkg::PH_HEADER: begin
                    hdr_dec  = (hdr_next != 4'd0) ? hdr_next - 4'd1 : 4'd0;
                    hdr_next = hdr_dec;
                    if (hdr_dec == 4'd0) begin
                        phase_next  = mtep_pkg::PH_DELTA;
                        acc_next    = '0;
                        dbytes_next = '0;
                    end
                end
                mtep_pkg::PH_DELTA: begin
                    if (dbytes_next >= 3'(mtep_pkg::MAX_DELTA_BYTES)) begin
                        phase_next = mtep_pkg::PH_EVENT;
                    end else begin
                        acc_next    = {acc_next[20:0], data_byte[6:0]};
                        dbytes_next = dbytes_next + 3'd1;
                        if (!data_byte[7]) begin
                            phase_next = mtep_pkg::PH_EVENT;
                        end
                    end
                end
                mtep_pkg::PH_EVENT: begin
                    if (data_byte == mtep_pkg::META_MARK) begin
                        phase_next = mtep_pkg::PH_META_TYPE;
                    end else if (mtep_pkg::is_long_status(data_byte[7:4]) ||
                                 mtep_pkg::is_short_status(data_byte[7:4])) begin
                        hstat_next = data_byte;
                        phase_next = mtep_pkg::PH_DATA1;
                    end else begin
                        phase_next  = mtep_pkg::PH_DELTA;
                        acc_next    = '0;
                        dbytes_next = '0;
                    end
                end
                mtep_pkg::PH_DATA1: begin
                    if (mtep_pkg::is_short_status(hstat_next[7:4])) begin
                        emit                = 1'b1;
                        result.event_kind   = mtep_pkg::KIND_CHANNEL;
                        result.status_byte  = hstat_next;
                        result.first_data   = data_byte;
                        phase_next          = mtep_pkg::PH_DELTA;
                        acc_next            = '0;
                        dbytes_next         = '0;
                    end else begin
                        hdata_next = data_byte;
                        phase_next = mtep_pkg::PH_DATA2;
                    end
                end
                mtep_pkg::PH_DATA2: begin
                    emit               = 1'b1;
                    result.event_kind  = mtep_pkg::KIND_CHANNEL;
                    result.status_byte = hstat_next;
                    result.first_data  = hdata_next;
                    result.second_data = data_byte;
                    result.has_second  = 1'b1;
                    phase_next         = mtep_pkg::PH_DELTA;
                    acc_next           = '0;
                    dbytes_next        = '0;
                end
                mtep_pkg::PH_META_TYPE: begin
                    if (data_byte == mtep_pkg::META_END) begin
                        phase_next = mtep_pkg::PH_END_LEN;
                    end else if (data_byte == mtep_pkg::META_TEMPO) begin
                        phase_next = mtep_pkg::PH_TEMPO_LEN;
                    end else begin
                        phase_next = mtep_pkg::PH_META_LEN;
                    end
                end
                mtep_pkg::PH_END_LEN: begin
                    emit              = 1'b1;
                    result.event_kind = mtep_pkg::KIND_END;
                    done_next         = 1'b1;
                    phase_next        = mtep_pkg::PH_HEADER;
                end
                mtep_pkg::PH_TEMPO_LEN: begin
                    tbytes_next = '0;
                    hdata_next  = '0;
                    mleft_next  = '0;
                    phase_next  = mtep_pkg::PH_TEMPO_DATA;
                end
                mtep_pkg::PH_TEMPO_DATA: begin
                    if (tbytes_next == 2'd0) begin
                        mleft_next  = data_byte;
                        tbytes_next = 2'd1;
                    end else if (tbytes_next == 2'd1) begin
                        hdata_next  = data_byte;
                        tbytes_next = 2'd2;
                    end else begin
                        tempo_next        = {mleft_next, hdata_next, data_byte};
                        tbytes_next       = '0;
                        mleft_next        = '0;
                        emit              = 1'b1;
                        result.event_kind = mtep_pkg::KIND_TEMPO;
                        result.tempo_us   = {mleft_reg, hdata_reg, data_byte};
                        phase_next        = mtep_pkg::PH_DELTA;
                        acc_next          = '0;
                        dbytes_next       = '0;
                    end
                end
                mtep_pkg::PH_META_LEN: begin
                    mleft_next = data_byte;
                    if (data_byte == 8'd0) begin
                        phase_next  = mtep_pkg::PH_DELTA;
                        acc_next    = '0;
                        dbytes_next = '0;
                    end else begin
                        phase_next = mtep_pkg::PH_META_SKIP;
                    end
                end
                mtep_pkg::PH_META_SKIP: begin
                    mleft_dec  = (mleft_next != 8'd0) ? mleft_next - 8'd1 : 8'd0;
                    mleft_next = mleft_dec;
                    if (mleft_dec == 8'd0) begin
                        phase_next  = mtep_pkg::PH_DELTA;
                        acc_next    = '0;
                        dbytes_next = '0;
                    end
                end
                default: begin
                    phase_next = mtep_pkg::PH_HEADER;
                    hdr_next   = mtep_pkg::HEADER_BYTES;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= mtep_pkg::PH_HEADER;
            hdr_reg    <= mtep_pkg::HEADER_BYTES;
            acc_reg    <= '0;
            dbytes_reg <= '0;
            hstat_reg  <= '0;
            hdata_reg  <= '0;
            mleft_reg  <= '0;
            tempo_reg  <= mtep_pkg::TEMPO_DEFAULT;
            tbytes_reg <= '0;
            done_reg   <= 1'b0;
        end else if (step) begin
            phase_reg  <= phase_next;
            hdr_reg    <= hdr_next;
            acc_reg    <= acc_next;
            dbytes_reg <= dbytes_next;
            hstat_reg  <= hstat_next;
            hdata_reg  <= hdata_next;
            mleft_reg  <= mleft_next;
            tempo_reg  <= tempo_next;
            tbytes_reg <= tbytes_next;
            done_reg   <= done_next;
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import mtep_pkg::*;

    localparam int LIMIT = 300000;
    localparam int DIR_N = 30;

    typedef struct packed {
        logic [7:0] b;
        logic       st;
        logic       typed;
        result_t    want;
    } stim_row_t;

    localparam result_t NO_RES = '0;
    localparam result_t R_BEND = {KIND_CHANNEL, 8'hE5, 8'h80, 8'hFF, 1'b1, 28'hFFFFFFF,
                                  TEMPO_DEFAULT};
    localparam result_t R_TMAX = {KIND_TEMPO, 8'h00, 8'h00, 8'h00, 1'b0, 28'd0, 24'hFFFFFF};
    localparam result_t R_END  = {KIND_END, 8'h00, 8'h00, 8'h00, 1'b0, 28'd0, 24'hFFFFFF};

    // header, long delta, pitch bend, ignored byte, max tempo, end of track, byte after end
    localparam stim_row_t DIR_TAB [DIR_N] = '{
        {8'h4D, 1'b1, 1'b0, NO_RES}, {8'h54, 1'b0, 1'b0, NO_RES},
        {8'h72, 1'b0, 1'b0, NO_RES}, {8'h6B, 1'b0, 1'b0, NO_RES},
        {8'h00, 1'b0, 1'b0, NO_RES}, {8'h00, 1'b0, 1'b0, NO_RES},
        {8'h00, 1'b0, 1'b0, NO_RES}, {8'hFF, 1'b0, 1'b0, NO_RES},
        {8'hFF, 1'b0, 1'b0, NO_RES}, {8'hFF, 1'b0, 1'b0, NO_RES},
        {8'hFF, 1'b0, 1'b0, NO_RES}, {8'hFF, 1'b0, 1'b0, NO_RES},
        {8'h00, 1'b0, 1'b0, NO_RES}, {8'hE5, 1'b0, 1'b0, NO_RES},
        {8'h80, 1'b0, 1'b0, NO_RES}, {8'hFF, 1'b0, 1'b1, R_BEND},
        {8'h00, 1'b0, 1'b0, NO_RES}, {8'h7F, 1'b0, 1'b0, NO_RES},
        {8'h00, 1'b0, 1'b0, NO_RES}, {8'hFF, 1'b0, 1'b0, NO_RES},
        {8'h51, 1'b0, 1'b0, NO_RES}, {8'h03, 1'b0, 1'b0, NO_RES},
        {8'hFF, 1'b0, 1'b0, NO_RES}, {8'hFF, 1'b0, 1'b0, NO_RES},
        {8'hFF, 1'b0, 1'b1, R_TMAX}, {8'h00, 1'b0, 1'b0, NO_RES},
        {8'hFF, 1'b0, 1'b0, NO_RES}, {8'h2F, 1'b0, 1'b0, NO_RES},
        {8'h00, 1'b0, 1'b1, R_END},  {8'h90, 1'b0, 1'b0, NO_RES}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_track_start = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_event_kind;
    logic [7:0]  m_status_byte;
    logic [7:0]  m_first_data;
    logic [7:0]  m_second_data;
    logic        m_has_second;
    logic [27:0] m_delta_ticks;
    logic [23:0] m_tempo_us;

    midi_track_event_parser u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_track_start (s_track_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_kind  (m_event_kind),
        .m_status_byte (m_status_byte),
        .m_first_data  (m_first_data),
        .m_second_data (m_second_data),
        .m_has_second  (m_has_second),
        .m_delta_ticks (m_delta_ticks),
        .m_tempo_us    (m_tempo_us)
    );

    always #4 aclk = ~aclk;

    // parser model state
    logic [3:0]  pstate;
    logic [3:0]  hdr_left;
    logic [27:0] vlq_acc;
    int          vlq_cnt;
    logic [7:0]  stat_hold;
    logic [7:0]  data_hold;
    logic [7:0]  skip_left;
    logic [23:0] tempo_cur;
    int          tempo_cnt;
    logic        halted;

    result_t     event_q[$];
    result_t     in_want = '0;
    logic        in_typed = 1'b0;
    result_t     new_res;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          items_taken = 0;
    int          errors = 0;
    int          cycles = 0;

    function automatic void restart_delta();
        pstate = PH_DELTA;
        vlq_acc = '0;
        vlq_cnt = 0;
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, input logic st, output result_t r);
        bit hit;
        hit = 1'b0;
        r = '0;
        if (st) begin
            pstate = PH_HEADER;
            hdr_left = HEADER_BYTES;
            vlq_acc = '0;
            vlq_cnt = 0;
            stat_hold = '0;
            data_hold = '0;
            skip_left = '0;
            tempo_cnt = 0;
            halted = 1'b0;
        end
        if (!halted) begin
            case (pstate)
                PH_HEADER: begin
                    if (hdr_left != 0) hdr_left--;
                    if (hdr_left == 0) restart_delta();
                end
                PH_DELTA: begin
                    if (vlq_cnt >= MAX_DELTA_BYTES) begin
                        pstate = PH_EVENT;
                    end else begin
                        vlq_acc = {vlq_acc[20:0], b[6:0]};
                        vlq_cnt++;
                        if (!b[7]) pstate = PH_EVENT;
                    end
                end
                PH_EVENT: begin
                    if (b == META_MARK) begin
                        pstate = PH_META_TYPE;
                    end else begin
                        case (b[7:4])
                            NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_AT, NIB_CONTROL, NIB_PITCH,
                            NIB_PROGRAM, NIB_CHAN_AT: begin
                                stat_hold = b;
                                pstate = PH_DATA1;
                            end
                            default: restart_delta();
                        endcase
                    end
                end
                PH_DATA1: begin
                    if (stat_hold[7:4] == NIB_PROGRAM || stat_hold[7:4] == NIB_CHAN_AT) begin
                        r = {KIND_CHANNEL, stat_hold, b, 8'h00, 1'b0, vlq_acc, tempo_cur};
                        hit = 1'b1;
                        restart_delta();
                    end else begin
                        data_hold = b;
                        pstate = PH_DATA2;
                    end
                end
                PH_DATA2: begin
                    r = {KIND_CHANNEL, stat_hold, data_hold, b, 1'b1, vlq_acc, tempo_cur};
                    hit = 1'b1;
                    restart_delta();
                end
                PH_META_TYPE: begin
                    if (b == META_END) pstate = PH_END_LEN;
                    else if (b == META_TEMPO) pstate = PH_TEMPO_LEN;
                    else pstate = PH_META_LEN;
                end
                PH_END_LEN: begin
                    r = {KIND_END, 8'h00, 8'h00, 8'h00, 1'b0, vlq_acc, tempo_cur};
                    hit = 1'b1;
                    halted = 1'b1;
                    pstate = PH_HEADER;
                end
                PH_TEMPO_LEN: begin
                    tempo_cnt = 0;
                    data_hold = '0;
                    skip_left = '0;
                    pstate = PH_TEMPO_DATA;
                end
                PH_TEMPO_DATA: begin
                    if (tempo_cnt == 0) begin
                        skip_left = b;
                        tempo_cnt = 1;
                    end else if (tempo_cnt == 1) begin
                        data_hold = b;
                        tempo_cnt = 2;
                    end else begin
                        tempo_cur = {skip_left, data_hold, b};
                        tempo_cnt = 0;
                        skip_left = '0;
                        r = {KIND_TEMPO, 8'h00, 8'h00, 8'h00, 1'b0, vlq_acc, tempo_cur};
                        hit = 1'b1;
                        restart_delta();
                    end
                end
                PH_META_LEN: begin
                    skip_left = b;
                    if (skip_left == 0) restart_delta();
                    else pstate = PH_META_SKIP;
                end
                PH_META_SKIP: begin
                    if (skip_left != 0) skip_left--;
                    if (skip_left == 0) restart_delta();
                end
                default: begin
                    pstate = PH_HEADER;
                    hdr_left = HEADER_BYTES;
                end
            endcase
        end
        return hit;
    endfunction

    task automatic check_event(input result_t got);
        result_t want;
        if (event_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: kind %0d status %h d1 %h d2 %h two %b delta %0d tempo %0d",
                         got.event_kind, got.status_byte, got.first_data, got.second_data,
                         got.has_second, got.delta_ticks, got.tempo_us);
        end else begin
            want = event_q.pop_front();
            if (got.event_kind !== want.event_kind || got.status_byte !== want.status_byte ||
                got.first_data !== want.first_data || got.second_data !== want.second_data ||
                got.has_second !== want.has_second || got.delta_ticks !== want.delta_ticks ||
                got.tempo_us !== want.tempo_us) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch expected: kind %0d status %h d1 %h d2 %h two %b delta %0d tempo %0d",
                             want.event_kind, want.status_byte, want.first_data,
                             want.second_data, want.has_second, want.delta_ticks, want.tempo_us);
                    $display("           actual: kind %0d status %h d1 %h d2 %h two %b delta %0d tempo %0d",
                             got.event_kind, got.status_byte, got.first_data, got.second_data,
                             got.has_second, got.delta_ticks, got.tempo_us);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (!halted || s_track_start) items_taken++;
                if (parse_byte(s_data_byte, s_track_start, new_res))
                    event_q.push_back(in_typed ? in_want : new_res);
            end
            if (m_valid && m_ready)
                check_event({m_event_kind, m_status_byte, m_first_data, m_second_data,
                             m_has_second, m_delta_ticks, m_tempo_us});
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_item(input logic [7:0] b, input logic st, input logic typed,
                             input result_t want);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_track_start <= st;
        in_typed <= typed;
        in_want <= want;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic put_byte(input logic [7:0] b);
        send_item(b, 1'b0, 1'b0, NO_RES);
    endtask

    task automatic put_delta();
        int r;
        int n;
        r = $urandom_range(19);
        n = (r < 12) ? 1 : (r < 16) ? 2 : (r < 18) ? 3 : (r < 19) ? 4 : 5;
        for (int i = 0; i < n - 1; i++)
            put_byte(8'h80 | 8'($urandom_range(127)));
        if (n == 5) put_byte(8'($urandom_range(255)));
        else put_byte(8'($urandom_range(127)));
    endtask

    task automatic put_track();
        int         n_ev;
        int         pick;
        int         len;
        logic [3:0] nib;
        logic [7:0] mtype;
        send_item(8'($urandom_range(255)), 1'b1, 1'b0, NO_RES);
        for (int i = 0; i < 7; i++) put_byte(8'($urandom_range(255)));
        n_ev = $urandom_range(1, 10);
        for (int e = 0; e < n_ev; e++) begin
            if ($urandom_range(39) == 0) return;
            put_delta();
            pick = $urandom_range(99);
            if (pick < 40) begin
                case ($urandom_range(4))
                    0: nib = NIB_NOTE_OFF;
                    1: nib = NIB_NOTE_ON;
                    2: nib = NIB_POLY_AT;
                    3: nib = NIB_CONTROL;
                    default: nib = NIB_PITCH;
                endcase
                put_byte({nib, 4'($urandom_range(15))});
                put_byte(8'($urandom_range(255)));
                put_byte(8'($urandom_range(255)));
            end else if (pick < 60) begin
                nib = $urandom_range(1) ? NIB_PROGRAM : NIB_CHAN_AT;
                put_byte({nib, 4'($urandom_range(15))});
                put_byte(8'($urandom_range(255)));
            end else if (pick < 72) begin
                put_byte(META_MARK);
                put_byte(META_TEMPO);
                put_byte(8'($urandom_range(255)));
                for (int i = 0; i < 3; i++) put_byte(8'($urandom_range(255)));
            end else if (pick < 84) begin
                do mtype = 8'($urandom_range(255));
                while (mtype == META_END || mtype == META_TEMPO);
                len = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(4);
                put_byte(META_MARK);
                put_byte(mtype);
                put_byte(8'(len));
                for (int i = 0; i < len; i++) put_byte(8'($urandom_range(255)));
            end else if (pick < 94) begin
                put_byte($urandom_range(1) ? 8'($urandom_range(127))
                                           : 8'($urandom_range(8'hF0, 8'hFE)));
            end else begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) put_byte(8'($urandom_range(255)));
            end
        end
        put_delta();
        put_byte(META_MARK);
        put_byte(META_END);
        put_byte(8'($urandom_range(255)));
        if ($urandom_range(2) == 0) begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++) put_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic drain_events();
        s_valid <= 1'b0;
        while (event_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic run_phase(input int s_pct, input int r_pct, input int goal);
        idle_pct = s_pct;
        stall_pct = r_pct;
        while (items_taken < goal) put_track();
        drain_events();
    endtask

    initial begin
        pstate = PH_HEADER;
        hdr_left = HEADER_BYTES;
        vlq_acc = '0;
        vlq_cnt = 0;
        stat_hold = '0;
        data_hold = '0;
        skip_left = '0;
        tempo_cur = TEMPO_DEFAULT;
        tempo_cnt = 0;
        halted = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < DIR_N; i++)
            send_item(DIR_TAB[i].b, DIR_TAB[i].st, DIR_TAB[i].typed, DIR_TAB[i].want);
        drain_events();
        run_phase(0, 0, 255);
        run_phase(71, 0, 480);
        run_phase(0, 71, 705);
        run_phase(30, 30, 930);
        repeat (8) @(posedge aclk);
        if (errors == 0 && event_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/mtep_pkg.sv
src/mtep_parser.sv
src/midi_track_event_parser.sv
tb/tb.sv
